// ===== hdl/ilfd_pkg.sv =====
// shared types, constants and helper functions for the instruction length field decoder
// no dependencies; imported by ilfd_decode, instruction_length_field_decoder and tb_top
package ilfd_pkg;

	// operation classes, numbered in prefix table order
	localparam logic [4:0] CLS_MOV_RM      = 5'd0;
	localparam logic [4:0] CLS_MOV_IMM_RM  = 5'd1;
	localparam logic [4:0] CLS_MOV_IMM_REG = 5'd2;
	localparam logic [4:0] CLS_MOV_MEM_ACC = 5'd3;
	localparam logic [4:0] CLS_MOV_ACC_MEM = 5'd4;
	localparam logic [4:0] CLS_IMM_GRP     = 5'd5;
	localparam logic [4:0] CLS_ADD_RM      = 5'd6;
	localparam logic [4:0] CLS_ADD_ACC     = 5'd7;
	localparam logic [4:0] CLS_SUB_RM      = 5'd8;
	localparam logic [4:0] CLS_SUB_ACC     = 5'd9;
	localparam logic [4:0] CLS_CMP_RM      = 5'd10;
	localparam logic [4:0] CLS_CMP_ACC     = 5'd11;
	localparam logic [4:0] CLS_JCC_FIRST   = 5'd12;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_OP  = 2'd1;
	localparam logic [1:0] ST_BAD_GRP = 2'd2;

	// immediate group operations and their reg selectors
	localparam logic [1:0] GRP_ADD = 2'd0;
	localparam logic [1:0] GRP_SUB = 2'd1;
	localparam logic [1:0] GRP_CMP = 2'd2;
	localparam logic [2:0] SEL_ADD = 3'b000;
	localparam logic [2:0] SEL_SUB = 3'b101;
	localparam logic [2:0] SEL_CMP = 3'b111;

	// mod field codes and the direct address r/m code
	localparam logic [1:0] MOD_MEM = 2'b00;
	localparam logic [1:0] MOD_D8  = 2'b01;
	localparam logic [1:0] MOD_D16 = 2'b10;
	localparam logic [2:0] RM_DIRECT = 3'b110;

	localparam int NUM_CLASSES = 32;

	// opcode prefix table as value and mask pairs, lowest index wins
	localparam logic [7:0] PFX_VAL [NUM_CLASSES] = '{
		8'h88, 8'hC6, 8'hB0, 8'hA0, 8'hA2, 8'h80, 8'h00, 8'h04,
		8'h28, 8'h2C, 8'h38, 8'h3C,
		8'h74, 8'h7C, 8'h7E, 8'h72, 8'h76, 8'h7A, 8'h70, 8'h78,
		8'h75, 8'h7D, 8'h7F, 8'h73, 8'h77, 8'h7B, 8'h79, 8'h71,
		8'hE2, 8'hE1, 8'hE0, 8'hE3
	};
	localparam logic [7:0] PFX_MASK [NUM_CLASSES] = '{
		8'hFC, 8'hFE, 8'hF0, 8'hFE, 8'hFE, 8'hFC, 8'hFC, 8'hFE,
		8'hFC, 8'hFE, 8'hFC, 8'hFE,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	typedef struct packed {
		logic       hit;
		logic [4:0] cls;
	} match_t;

	// bytes of the instruction in flight, sorted by role
	typedef struct packed {
		logic [7:0] opcode;
		logic [7:0] modrm;
		logic [7:0] disp_lo;
		logic [7:0] disp_hi;
		logic [7:0] imm_lo;
		logic [7:0] imm_hi;
	} ibytes_t;

	// one decoded record
	typedef struct packed {
		logic [4:0]  op_class;
		logic [1:0]  group_op;
		logic        wide_bit;
		logic        direction_bit;
		logic        sign_ext_bit;
		logic [1:0]  mode_field;
		logic [2:0]  reg_field;
		logic [2:0]  rm_field;
		logic [15:0] displacement;
		logic [15:0] immediate;
		logic [2:0]  length;
		logic [1:0]  status;
	} record_t;

	// prefix match over the whole table
	function automatic match_t match_class(input logic [7:0] b);
		match_t r;
		r = '0;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if ((b & PFX_MASK[i]) == PFX_VAL[i]) begin
				r.hit = 1'b1;
				r.cls = 5'(i);
			end
		end
		return r;
	endfunction

	function automatic logic has_modrm(input logic [4:0] cls);
		return (cls == CLS_MOV_RM) || (cls == CLS_MOV_IMM_RM) || (cls == CLS_IMM_GRP) ||
			(cls == CLS_ADD_RM) || (cls == CLS_SUB_RM) || (cls == CLS_CMP_RM);
	endfunction

	function automatic logic is_reg_rm(input logic [4:0] cls);
		return (cls == CLS_MOV_RM) || (cls == CLS_ADD_RM) || (cls == CLS_SUB_RM) ||
			(cls == CLS_CMP_RM);
	endfunction

	// displacement byte count set by the mod/rm byte
	function automatic logic [1:0] disp_count(input logic [7:0] modrm);
		logic [1:0] d;
		d = 2'd0;
		if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT) d = 2'd2;
		else if (modrm[7:6] == MOD_D8) d = 2'd1;
		else if (modrm[7:6] == MOD_D16) d = 2'd2;
		return d;
	endfunction

	function automatic logic [15:0] sext8(input logic [7:0] x);
		return {{8{x[7]}}, x};
	endfunction

endpackage

// ===== hdl/ilfd_decode.sv =====
// field decoder: turns the sorted bytes of one framed instruction into a record
// depends on ilfd_pkg
module ilfd_decode (
	input  logic [4:0]       op_class,
	input  ilfd_pkg::ibytes_t ib,
	input  logic [2:0]       length,
	output ilfd_pkg::record_t rec
);
	import ilfd_pkg::*;

	logic       w;
	logic       s;
	logic [1:0] d;

	assign w = ib.opcode[0];
	assign s = ib.opcode[1];
	assign d = disp_count(ib.modrm);

	// per-class field selection
	always_comb begin
		rec          = '0;
		rec.op_class = op_class;
		rec.length   = length;
		rec.status   = ST_OK;
		if (has_modrm(op_class)) begin
			rec.wide_bit   = w;
			rec.mode_field = ib.modrm[7:6];
			rec.reg_field  = ib.modrm[5:3];
			rec.rm_field   = ib.modrm[2:0];
			if (d == 2'd1) rec.displacement = sext8(ib.disp_lo);
			else if (d == 2'd2) rec.displacement = {ib.disp_hi, ib.disp_lo};
			if (is_reg_rm(op_class)) begin
				rec.direction_bit = s;
			end else if (op_class == CLS_IMM_GRP) begin
				rec.sign_ext_bit = s;
				case (ib.modrm[5:3])
					SEL_ADD: rec.group_op = GRP_ADD;
					SEL_SUB: rec.group_op = GRP_SUB;
					SEL_CMP: rec.group_op = GRP_CMP;
					default: rec.status = ST_BAD_GRP;
				endcase
				if (w && !s) rec.immediate = {ib.imm_hi, ib.imm_lo};
				else if (w) rec.immediate = sext8(ib.imm_lo);
				else rec.immediate = {8'h00, ib.imm_lo};
			end else begin
				rec.immediate = w ? {ib.imm_hi, ib.imm_lo} : {8'h00, ib.imm_lo};
			end
		end else if (op_class >= CLS_JCC_FIRST) begin
			rec.displacement = sext8(ib.modrm);
		end else if (op_class == CLS_MOV_IMM_REG) begin
			rec.wide_bit  = ib.opcode[3];
			rec.reg_field = ib.opcode[2:0];
			rec.immediate = ib.opcode[3] ? {ib.imm_hi, ib.modrm} : {8'h00, ib.modrm};
		end else if (op_class == CLS_MOV_MEM_ACC || op_class == CLS_MOV_ACC_MEM) begin
			rec.wide_bit  = w;
			rec.immediate = {ib.imm_hi, ib.modrm};
		end else begin
			rec.wide_bit  = w;
			rec.immediate = w ? {ib.imm_hi, ib.modrm} : {8'h00, ib.modrm};
		end
	end

endmodule

// ===== hdl/instruction_length_field_decoder.sv =====
// top level: frames a code byte stream into 16-bit x86 instructions and emits decoded records
// depends on ilfd_pkg and ilfd_decode
//
// channel   dir  width  contents
// s_axis    in   8      code_byte
// m_axis    out  56     one decoded record per instruction, or per unknown opcode byte
//
// one code byte per cycle is taken, with no gaps between instructions, while m_axis keeps up
// the last byte of an instruction is decoded from the input register; its record then
// leaves from the result register
// reset clears the framing state and both valid flags; the next byte is an opcode
// a stalled m_axis holds the result register; input stalls only when a new record is due
// while that register is still full
module instruction_length_field_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] code_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] op_class, [6:5] group_op, [7] wide_bit, [8] direction_bit, [9] sign_ext_bit,
	// [11:10] mode_field, [14:12] reg_field, [17:15] rm_field, [33:18] displacement,
	// [49:34] immediate, [52:50] length, [54:53] status, [55] zero
	output logic [55:0] m_axis_tdata
);
	import ilfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] pos_q;
	logic [2:0] exp_q;
	logic [4:0] cls_q;
	ibytes_t    bytes_q;
	logic       out_valid_q;
	record_t    out_rec_q;

	match_t     m;
	ibytes_t    bytes_n;
	logic [2:0] exp_eff;
	logic [2:0] k;
	logic [2:0] j;
	logic [1:0] dc;
	logic       done;
	logic       emit;
	logic       out_free;
	logic       advance;
	record_t    dec_rec;
	record_t    bad_rec;
	record_t    rec_n;

	// length once the mod/rm byte is known
	function automatic logic [2:0] len_modrm(input logic [4:0] cls, input logic [7:0] op,
		input logic [7:0] mrm);
		logic [2:0] base;
		base = 3'd2 + {1'b0, disp_count(mrm)};
		if (cls == CLS_IMM_GRP) return base + ((op[0] && !op[1]) ? 3'd2 : 3'd1);
		if (cls == CLS_MOV_IMM_RM) return base + (op[0] ? 3'd2 : 3'd1);
		return base;
	endfunction

	// length known from the opcode alone
	function automatic logic [2:0] len_opcode(input logic [4:0] cls, input logic [7:0] op);
		if (cls >= CLS_JCC_FIRST) return 3'd2;
		if (cls == CLS_MOV_IMM_REG) return op[3] ? 3'd3 : 3'd2;
		if (cls == CLS_ADD_ACC || cls == CLS_SUB_ACC || cls == CLS_CMP_ACC)
			return op[0] ? 3'd3 : 3'd2;
		return 3'd3;
	endfunction

	// input register
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// byte routing and framing
	assign m  = match_class(byte_s1);
	assign dc = disp_count(bytes_q.modrm);
	assign k  = pos_q - 3'd2;
	assign j  = k - {1'b0, dc};

	always_comb begin
		bytes_n = bytes_q;
		exp_eff = exp_q;
		if (pos_q == 3'd0) begin
			bytes_n.opcode = byte_s1;
		end else if (pos_q == 3'd1) begin
			bytes_n.modrm = byte_s1;
			if (exp_q == 3'd0) exp_eff = len_modrm(cls_q, bytes_q.opcode, byte_s1);
		end else if (has_modrm(cls_q)) begin
			if (k < {1'b0, dc}) begin
				if (k == 3'd0) bytes_n.disp_lo = byte_s1;
				else bytes_n.disp_hi = byte_s1;
			end else begin
				if (j == 3'd0) bytes_n.imm_lo = byte_s1;
				else bytes_n.imm_hi = byte_s1;
			end
		end else begin
			bytes_n.imm_hi = byte_s1;
		end
	end

	assign done = ({1'b0, pos_q} + 4'd1) >= {1'b0, exp_eff};
	assign emit = (pos_q == 3'd0) ? !m.hit : done;

	ilfd_decode u_decode (
		.op_class (cls_q),
		.ib       (bytes_n),
		.length   (exp_eff),
		.rec      (dec_rec)
	);

	// unknown opcode record
	always_comb begin
		bad_rec        = '0;
		bad_rec.length = 3'd1;
		bad_rec.status = ST_BAD_OP;
	end

	assign rec_n = (pos_q == 3'd0) ? bad_rec : dec_rec;

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			exp_q <= 3'd0;
			cls_q <= 5'd0;
		end else if (advance) begin
			if (pos_q == 3'd0) begin
				if (m.hit) begin
					cls_q <= m.cls;
					pos_q <= 3'd1;
					exp_q <= has_modrm(m.cls) ? 3'd0 : len_opcode(m.cls, byte_s1);
				end else begin
					pos_q <= 3'd0;
					exp_q <= 3'd0;
				end
			end else if (done) begin
				pos_q <= 3'd0;
				exp_q <= 3'd0;
			end else begin
				pos_q <= pos_q + 3'd1;
				exp_q <= exp_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bytes_q <= bytes_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_rec_q <= rec_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0,
		out_rec_q.status, out_rec_q.length, out_rec_q.immediate, out_rec_q.displacement,
		out_rec_q.rm_field, out_rec_q.reg_field, out_rec_q.mode_field,
		out_rec_q.sign_ext_bit, out_rec_q.direction_bit, out_rec_q.wide_bit,
		out_rec_q.group_op, out_rec_q.op_class};

	// checks on the framing state and the result handoff
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 3'd5)
		else $error("byte position beyond the longest instruction");

	a_len_known: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q >= 3'd2 |-> (exp_q >= 3'd3 && exp_q <= 3'd6))
		else $error("instruction length unknown past the mod/rm byte");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> m_axis_tvalid)
		else $error("record emitted but result register not valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !(advance && emit))
		else $error("pending record overwritten");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input refused with empty input register");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for instruction_length_field_decoder: streams code bytes in,
// predicts each decoded instruction record and compares the output words field by field
// depends on ilfd_pkg (record type and codes) and the decoder top level
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ilfd_pkg::*;

	localparam logic [1:0] MOD_REG = 2'b11;
	localparam int DIRECTED_ROWS = 27;

	// opcode prefixes and their significant bit counts, first hit wins
	localparam logic [7:0] OPC_PREFIX [32] = '{
		8'h22, 8'h63, 8'h0B, 8'h50, 8'h51, 8'h20, 8'h00, 8'h02,
		8'h0A, 8'h16, 8'h0E, 8'h1E,
		8'h74, 8'h7C, 8'h7E, 8'h72, 8'h76, 8'h7A, 8'h70, 8'h78,
		8'h75, 8'h7D, 8'h7F, 8'h73, 8'h77, 8'h7B, 8'h79, 8'h71,
		8'hE2, 8'hE1, 8'hE0, 8'hE3
	};
	localparam int OPC_BITS [32] = '{
		6, 7, 4, 7, 7, 6, 6, 7, 6, 7, 6, 7,
		8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8, 8
	};

	// directed code bytes, one word per row
	localparam logic [7:0] DIRECTED_CODE [DIRECTED_ROWS] = '{
		8'hFF,                                      // unknown opcode right after reset
		8'h00, 8'hC0,                               // add r/m8,reg8 register form
		8'h83, 8'hFF, 8'h80,                        // cmp group, s and w set, negative byte
		8'h80, 8'h08, 8'h12,                        // immediate group, invalid selector
		8'h89, 8'h86, 8'h34, 8'h12,                 // mov with 16-bit displacement
		8'hC7, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF,   // longest form: direct address, word imm
		8'hBF, 8'h34, 8'h12,                        // mov word immediate to register 7
		8'hE3, 8'h80,                               // jcxz with most negative offset
		8'h2B, 8'h45, 8'h80                         // sub, d set, negative byte displacement
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] code_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [4:0] op_class, [6:5] group_op, [7] wide_bit, [8] direction_bit, [9] sign_ext_bit,
	// [11:10] mode_field, [14:12] reg_field, [17:15] rm_field, [33:18] displacement,
	// [49:34] immediate, [52:50] length, [54:53] status, [55] zero
	logic [55:0] m_axis_tdata;

	// decoded records still owed by the block, oldest first
	record_t pending_records [$];

	// framing state of the predictor
	int         frame_pos = 0;
	int         frame_len = 0;
	logic [4:0] frame_cls = '0;
	logic [7:0] frame_bytes [6] = '{default: 8'h00};

	int mismatches = 0;
	int records_seen = 0;
	int bytes_sent = 0;
	int send_burst = 0;
	bit long_hold_done = 1'b0;

	instruction_length_field_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// opcode classification and length rules
	function automatic int lookup_class(logic [7:0] b);
		for (int i = 0; i < 32; i++)
			if ((b >> (8 - OPC_BITS[i])) == OPC_PREFIX[i]) return i;
		return -1;
	endfunction

	function automatic bit uses_modrm(logic [4:0] cls);
		return cls == CLS_MOV_RM || cls == CLS_MOV_IMM_RM || cls == CLS_IMM_GRP ||
			cls == CLS_ADD_RM || cls == CLS_SUB_RM || cls == CLS_CMP_RM;
	endfunction

	function automatic int disp_bytes(logic [7:0] modrm);
		case (modrm[7:6])
			MOD_MEM: return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
			MOD_D8:  return 1;
			MOD_D16: return 2;
			default: return 0;
		endcase
	endfunction

	function automatic logic [15:0] widen8(logic [7:0] x);
		return {{8{x[7]}}, x};
	endfunction

	function automatic int frame_length(logic [4:0] cls, logic [7:0] b0, logic [7:0] b1);
		if (cls >= CLS_JCC_FIRST) return 2;
		case (cls)
			CLS_MOV_RM, CLS_ADD_RM, CLS_SUB_RM, CLS_CMP_RM: return 2 + disp_bytes(b1);
			CLS_IMM_GRP:     return 2 + disp_bytes(b1) + ((b0[0] && !b0[1]) ? 2 : 1);
			CLS_MOV_IMM_RM:  return 2 + disp_bytes(b1) + (b0[0] ? 2 : 1);
			CLS_MOV_IMM_REG: return 1 + (b0[3] ? 2 : 1);
			CLS_ADD_ACC, CLS_SUB_ACC, CLS_CMP_ACC: return 1 + (b0[0] ? 2 : 1);
			default: return 3;
		endcase
	endfunction

	// field decode of the framed instruction
	function automatic record_t build_record();
		record_t r;
		logic [7:0] b0, b1;
		logic w, s;
		int d, p;
		r = '0;
		b0 = frame_bytes[0];
		b1 = frame_bytes[1];
		w = b0[0];
		s = b0[1];
		r.op_class = frame_cls;
		r.length = 3'(frame_len);
		r.status = ST_OK;
		if (uses_modrm(frame_cls)) begin
			d = disp_bytes(b1);
			p = 2 + d;
			r.wide_bit = w;
			r.mode_field = b1[7:6];
			r.reg_field = b1[5:3];
			r.rm_field = b1[2:0];
			if (d == 1) r.displacement = widen8(frame_bytes[2]);
			else if (d == 2) r.displacement = {frame_bytes[3], frame_bytes[2]};
			if (frame_cls == CLS_IMM_GRP) begin
				r.sign_ext_bit = s;
				case (r.reg_field)
					SEL_ADD: r.group_op = GRP_ADD;
					SEL_SUB: r.group_op = GRP_SUB;
					SEL_CMP: r.group_op = GRP_CMP;
					default: r.status = ST_BAD_GRP;
				endcase
				if (w && !s) r.immediate = {frame_bytes[p + 1], frame_bytes[p]};
				else if (w) r.immediate = widen8(frame_bytes[p]);
				else r.immediate = {8'h00, frame_bytes[p]};
			end else if (frame_cls == CLS_MOV_IMM_RM) begin
				r.immediate = w ? {frame_bytes[p + 1], frame_bytes[p]} : {8'h00, frame_bytes[p]};
			end else begin
				r.direction_bit = s;
			end
		end else if (frame_cls >= CLS_JCC_FIRST) begin
			r.displacement = widen8(b1);
		end else if (frame_cls == CLS_MOV_IMM_REG) begin
			r.wide_bit = b0[3];
			r.reg_field = b0[2:0];
			r.immediate = b0[3] ? {frame_bytes[2], b1} : {8'h00, b1};
		end else if (frame_cls == CLS_MOV_MEM_ACC || frame_cls == CLS_MOV_ACC_MEM) begin
			// address is always a full word
			r.wide_bit = w;
			r.immediate = {frame_bytes[2], b1};
		end else begin
			r.wide_bit = w;
			r.immediate = w ? {frame_bytes[2], b1} : {8'h00, b1};
		end
		return r;
	endfunction

	// advance the framing state by one accepted code byte
	task automatic decode_step(input logic [7:0] b, output bit done, output record_t rec);
		int c;
		done = 1'b0;
		rec = '0;
		if (frame_pos == 0) begin
			c = lookup_class(b);
			if (c < 0) begin
				rec.length = 3'd1;
				rec.status = ST_BAD_OP;
				done = 1'b1;
				frame_len = 0;
			end else begin
				frame_cls = 5'(c);
				frame_bytes[0] = b;
				frame_pos = 1;
				frame_len = uses_modrm(frame_cls) ? 0 : frame_length(frame_cls, b, 8'h00);
			end
		end else begin
			frame_bytes[frame_pos] = b;
			frame_pos++;
			if (frame_pos == 2 && frame_len == 0)
				frame_len = frame_length(frame_cls, frame_bytes[0], frame_bytes[1]);
			if (frame_pos >= frame_len) begin
				rec = build_record();
				done = 1'b1;
				frame_pos = 0;
				frame_len = 0;
			end
		end
	endtask

	function automatic record_t make_record(logic [4:0] cls, logic [1:0] grp, logic w,
			logic d, logic s, logic [1:0] mode, logic [2:0] rg, logic [2:0] rm,
			logic [15:0] disp, logic [15:0] imm, logic [2:0] len, logic [1:0] st);
		record_t r;
		r.op_class = cls;
		r.group_op = grp;
		r.wide_bit = w;
		r.direction_bit = d;
		r.sign_ext_bit = s;
		r.mode_field = mode;
		r.reg_field = rg;
		r.rm_field = rm;
		r.displacement = disp;
		r.immediate = imm;
		r.length = len;
		r.status = st;
		return r;
	endfunction

	// directed rows whose record is written out by hand
	function automatic bit known_record(int row, output record_t r);
		r = '0;
		case (row)
			// unknown opcode: every field but length and status is zero
			0: r = make_record(5'd0, GRP_ADD, 1'b0, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0,
				16'h0000, 16'h0000, 3'd1, ST_BAD_OP);
			2: r = make_record(CLS_ADD_RM, GRP_ADD, 1'b0, 1'b0, 1'b0, MOD_REG, 3'd0, 3'd0,
				16'h0000, 16'h0000, 3'd2, ST_OK);
			8: r = make_record(CLS_IMM_GRP, GRP_ADD, 1'b0, 1'b0, 1'b0, MOD_MEM, 3'd1, 3'd0,
				16'h0000, 16'h0012, 3'd3, ST_BAD_GRP);
			18: r = make_record(CLS_MOV_IMM_RM, GRP_ADD, 1'b1, 1'b0, 1'b0, MOD_MEM, 3'd0,
				RM_DIRECT, 16'hFFFF, 16'hFFFF, 3'd6, ST_OK);
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("record %0d %s is %0h, expected %0h",
				records_seen, name, got, want));
	endtask

	// sender idle length: mostly none or short, a few long, with idle-free bursts
	function automatic int sender_gap();
		int r;
		if (send_burst > 0) begin
			send_burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			send_burst = $urandom_range(30, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] data_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'h7F;
			2: return 8'h80;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// offer one code word, wait for acceptance, then predict
	task automatic send_code(input logic [7:0] code, input bit fixed, input record_t fixed_rec);
		int gap;
		bit done;
		record_t rec;
		gap = sender_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		decode_step(code, done, rec);
		if (done) pending_records = {pending_records, (fixed ? fixed_rec : rec)};
		bytes_sent++;
	endtask

	// well-formed instruction with random content, now and then cut short
	task automatic send_random_instruction();
		logic [7:0] op, modrm;
		int k, cls, total;
		bit with_modrm;
		k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 11) : $urandom_range(0, 31);
		op = 8'($urandom);
		op = (OPC_PREFIX[k] << (8 - OPC_BITS[k])) | (op & ((8'd1 << (8 - OPC_BITS[k])) - 8'd1));
		cls = lookup_class(op);
		with_modrm = uses_modrm(5'(cls));
		modrm = 8'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			modrm[7:6] = MOD_MEM;
			modrm[2:0] = RM_DIRECT;
		end
		// favor valid group selectors
		if (5'(cls) == CLS_IMM_GRP && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 2))
				0: modrm[5:3] = SEL_ADD;
				1: modrm[5:3] = SEL_SUB;
				default: modrm[5:3] = SEL_CMP;
			endcase
		end
		total = frame_length(5'(cls), op, modrm);
		if ($urandom_range(0, 24) == 0) total = $urandom_range(1, total - 1);
		send_code(op, 1'b0, '0);
		for (int i = 1; i < total; i++)
			send_code((i == 1 && with_modrm) ? modrm : data_byte(), 1'b0, '0);
	endtask

	// stimulus: reset, directed table, then random instruction stream
	initial begin : stimulus
		record_t fixed_rec;
		bit fixed;
		bit drained;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		drained = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			fixed = known_record(row, fixed_rec);
			send_code(DIRECTED_CODE[row], fixed, fixed_rec);
		end
		while (bytes_sent < 1775) begin
			// one pause with the input idle until every record is out
			if (!drained && bytes_sent >= 900) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_records.size() != 0) @(posedge clk);
				drained = 1'b1;
			end
			if ($urandom_range(0, 19) == 0) send_code(8'($urandom), 1'b0, '0);
			else send_random_instruction();
		end
		s_axis_tvalid <= 1'b0;
		while (pending_records.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end

	// output ready: random runs and stalls, one long hold to back up the input
	initial begin : receiver
		int run, stall, r;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && records_seen >= 150) begin
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
			m_axis_tready <= 1'b1;
			repeat (run) @(posedge clk);
			r = $urandom_range(0, 9);
			if (r < 6) stall = $urandom_range(1, 2);
			else if (r < 9) stall = $urandom_range(3, 6);
			else stall = $urandom_range(15, 40);
			m_axis_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// compare each accepted output word with the oldest predicted record
	always @(posedge clk) begin : output_check
		record_t seen, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.op_class = m_axis_tdata[4:0];
			seen.group_op = m_axis_tdata[6:5];
			seen.wide_bit = m_axis_tdata[7];
			seen.direction_bit = m_axis_tdata[8];
			seen.sign_ext_bit = m_axis_tdata[9];
			seen.mode_field = m_axis_tdata[11:10];
			seen.reg_field = m_axis_tdata[14:12];
			seen.rm_field = m_axis_tdata[17:15];
			seen.displacement = m_axis_tdata[33:18];
			seen.immediate = m_axis_tdata[49:34];
			seen.length = m_axis_tdata[52:50];
			seen.status = m_axis_tdata[54:53];
			records_seen++;
			compare_field("pad bit", 16'(m_axis_tdata[55]), 16'h0000);
			if (pending_records.size() == 0) begin
				report_mismatch($sformatf("record %0d arrived with none expected", records_seen));
			end else begin
				want = pending_records.pop_front();
				compare_field("op_class", 16'(seen.op_class), 16'(want.op_class));
				compare_field("group_op", 16'(seen.group_op), 16'(want.group_op));
				compare_field("wide_bit", 16'(seen.wide_bit), 16'(want.wide_bit));
				compare_field("direction_bit", 16'(seen.direction_bit),
					16'(want.direction_bit));
				compare_field("sign_ext_bit", 16'(seen.sign_ext_bit), 16'(want.sign_ext_bit));
				compare_field("mode_field", 16'(seen.mode_field), 16'(want.mode_field));
				compare_field("reg_field", 16'(seen.reg_field), 16'(want.reg_field));
				compare_field("rm_field", 16'(seen.rm_field), 16'(want.rm_field));
				compare_field("displacement", seen.displacement, want.displacement);
				compare_field("immediate", seen.immediate, want.immediate);
				compare_field("length", 16'(seen.length), 16'(want.length));
				compare_field("status", 16'(seen.status), 16'(want.status));
			end
		end
	end

	// hard stop if the stream hangs
	initial begin : watchdog
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end
endmodule
